FILE: src/pod_pkg.sv
`default_nettype none

package pod_pkg;

  typedef struct packed {
    logic [11:0] pixel_x;
    logic [11:0] pixel_y;
    logic [7:0]  red_in;
    logic [7:0]  green_in;
    logic [7:0]  blue_in;
    logic [2:0]  random_noise;
    logic [2:0]  random_color;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic [2:0] color_threshold;
    logic [2:0] alpha_threshold;
    logic [8:0] noise_word;
  } out_beat_t;

  typedef struct packed {
    logic [2:0] red_thr;
    logic [2:0] green_thr;
    logic [2:0] blue_thr;
    logic [2:0] alpha_thr;
    logic [2:0] noise;
  } thr_t;

  typedef enum logic [1:0] {
    CSEL_MAGIC  = 2'd0,
    CSEL_BAYER  = 2'd1,
    CSEL_RANDOM = 2'd2,
    CSEL_CONST  = 2'd3
  } csel_t;

  typedef enum logic [1:0] {
    ASEL_SAME  = 2'd0,
    ASEL_INV   = 2'd1,
    ASEL_NOISE = 2'd2,
    ASEL_ZERO  = 2'd3
  } asel_t;

  typedef enum logic [1:0] {
    NSEL_DRAW = 2'd0,
    NSEL_KEEP = 2'd1,
    NSEL_NONE = 2'd2,
    NSEL_RSVD = 2'd3
  } nsel_t;

  typedef enum logic [1:0] {
    REG_DITHER_MODE  = 2'd0,
    REG_NOISE_SELECT = 2'd1,
    REG_COLOR_DITHER = 2'd2,
    REG_UNUSED       = 2'd3
  } reg_idx_t;

  localparam int unsigned ADDR_W = 4;
  localparam int unsigned DATA_W = 32;

  localparam logic [3:0] DITHER_MODE_RST  = 4'd15;
  localparam logic [1:0] NOISE_SELECT_RST = 2'd0;
  localparam logic       COLOR_DITHER_RST = 1'b1;

  localparam logic [8:0] NOISE_TAG   = 9'h020;
  localparam logic [7:0] ROUND_LIMIT = 8'd247;
  localparam logic [7:0] ROUND_MASK  = 8'hF8;
  localparam logic [7:0] FULL_SCALE  = 8'hFF;
  localparam logic [7:0] ROUND_STEP  = 8'd8;
  localparam logic [2:0] CONST_THR   = 3'd7;
  localparam logic [2:0] GREEN_OFS   = 3'd3;
  localparam logic [2:0] BLUE_OFS    = 3'd5;

  localparam logic [2:0] BAYER_TAB [16] = '{
    3'd0, 3'd4, 3'd1, 3'd5,
    3'd4, 3'd0, 3'd5, 3'd1,
    3'd3, 3'd7, 3'd2, 3'd6,
    3'd7, 3'd3, 3'd6, 3'd2
  };

  localparam logic [2:0] MAGIC_TAB [16] = '{
    3'd0, 3'd6, 3'd1, 3'd7,
    3'd4, 3'd2, 3'd5, 3'd3,
    3'd3, 3'd5, 3'd2, 3'd4,
    3'd7, 3'd1, 3'd6, 3'd0
  };

endpackage

`default_nettype wire

FILE: src/pod_thresh.sv
`default_nettype none

module pod_thresh (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            adv,
  input  wire logic [3:0]      dither_mode,
  input  wire logic [1:0]      noise_select,
  input  wire pod_pkg::in_beat_t pix,
  output pod_pkg::thr_t        thr
);

  logic [2:0]      noise_r;
  logic [2:0]      noise_nxt;
  logic [3:0]      idx;
  logic [2:0]      entry;
  logic [2:0]      cdith;
  logic [2:0]      adith;
  pod_pkg::csel_t  csel;
  pod_pkg::asel_t  asel;
  pod_pkg::nsel_t  nsel;

  assign csel = pod_pkg::csel_t'(dither_mode[3:2]);
  assign asel = pod_pkg::asel_t'(dither_mode[1:0]);
  assign nsel = pod_pkg::nsel_t'(noise_select);
  assign idx  = {pix.pixel_y[1:0], pix.pixel_x[1:0]};

  assign noise_nxt = (nsel == pod_pkg::NSEL_DRAW) ? pix.random_noise : noise_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      noise_r <= '0;
    end else if (adv) begin
      noise_r <= noise_nxt;
    end
  end

  always_comb begin
    entry = pod_pkg::BAYER_TAB[idx];
    cdith = '0;
    adith = '0;
    if (csel == pod_pkg::CSEL_MAGIC || csel == pod_pkg::CSEL_RANDOM) begin
      entry = pod_pkg::MAGIC_TAB[idx];
    end
    if (nsel == pod_pkg::NSEL_DRAW || nsel == pod_pkg::NSEL_KEEP) begin
      case (csel)
        pod_pkg::CSEL_MAGIC,
        pod_pkg::CSEL_BAYER:  cdith = entry;
        pod_pkg::CSEL_RANDOM: cdith = pix.random_color;
        default:              cdith = pod_pkg::CONST_THR;
      endcase
      case (asel)
        pod_pkg::ASEL_SAME:  adith = entry;
        pod_pkg::ASEL_INV:   adith = ~entry;
        pod_pkg::ASEL_NOISE: adith = noise_nxt;
        default:             adith = '0;
      endcase
    end
  end

  always_comb begin
    thr.red_thr   = cdith;
    thr.green_thr = cdith;
    thr.blue_thr  = cdith;
    thr.alpha_thr = adith;
    thr.noise     = noise_nxt;
    if (csel == pod_pkg::CSEL_RANDOM) begin
      thr.green_thr = cdith + pod_pkg::GREEN_OFS;
      thr.blue_thr  = cdith + pod_pkg::BLUE_OFS;
    end
  end

endmodule

`default_nettype wire

FILE: src/pod_round.sv
`default_nettype none

module pod_round (
  input  wire logic       en,
  input  wire logic [7:0] value_in,
  input  wire logic [2:0] thr,
  output logic      [7:0] value_out
);

  always_comb begin
    value_out = value_in;
    if (en && (value_in[2:0] > thr)) begin
      if (value_in > pod_pkg::ROUND_LIMIT) begin
        value_out = pod_pkg::FULL_SCALE;
      end else begin
        value_out = (value_in & pod_pkg::ROUND_MASK) + pod_pkg::ROUND_STEP;
      end
    end
  end

endmodule

`default_nettype wire

FILE: src/pixel_ordered_dither_unit_core.sv
// An accepted beat enters the input register, then moves to the result register behind out_valid.
// Throughput: one beat per cycle while out_stall is low; input register feeds a result
// register through table lookup, compare and rounding logic.
// in_stall rises only while both the input and the result register are full and out_stall is high.
// Reset (rst_n low, synchronous) empties both registers, clears the noise register and
// loads dither_mode 15, noise_select 0, color_dither_enable 1.
`default_nettype none

module pixel_ordered_dither_unit_core (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire pod_pkg::in_beat_t             in_data,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output pod_pkg::out_beat_t                 out_data,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [pod_pkg::ADDR_W-1:0]    paddr,
  input  wire logic [pod_pkg::DATA_W-1:0]    pwdata,
  output logic      [pod_pkg::DATA_W-1:0]    prdata,
  output logic                               pready
);

  logic               s1_vld_r;
  logic               s1_vld_nxt;
  pod_pkg::in_beat_t  s1_r;
  logic               out_vld_r;
  logic               out_vld_nxt;
  pod_pkg::out_beat_t out_r;
  pod_pkg::out_beat_t out_nxt;
  logic               out_free;
  logic               adv;
  logic               in_acc;
  logic [3:0]         dither_mode_r;
  logic [1:0]         noise_select_r;
  logic               color_dither_r;
  logic               cfg_wr;
  pod_pkg::reg_idx_t  reg_idx;
  pod_pkg::thr_t      thr;

  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite && pready;
  assign reg_idx  = pod_pkg::reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dither_mode_r  <= pod_pkg::DITHER_MODE_RST;
      noise_select_r <= pod_pkg::NOISE_SELECT_RST;
      color_dither_r <= pod_pkg::COLOR_DITHER_RST;
    end else if (cfg_wr) begin
      case (reg_idx)
        pod_pkg::REG_DITHER_MODE:  dither_mode_r  <= pwdata[3:0];
        pod_pkg::REG_NOISE_SELECT: noise_select_r <= pwdata[1:0];
        pod_pkg::REG_COLOR_DITHER: color_dither_r <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      pod_pkg::REG_DITHER_MODE:  prdata = {28'd0, dither_mode_r};
      pod_pkg::REG_NOISE_SELECT: prdata = {30'd0, noise_select_r};
      pod_pkg::REG_COLOR_DITHER: prdata = {31'd0, color_dither_r};
      default:                   prdata = '0;
    endcase
  end

  assign out_free    = !out_vld_r || !out_stall;
  assign adv         = s1_vld_r && out_free;
  assign in_stall    = s1_vld_r && !out_free;
  assign in_acc      = in_valid && !in_stall;
  assign s1_vld_nxt  = in_acc || (s1_vld_r && !out_free);
  assign out_vld_nxt = adv || (out_vld_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      s1_vld_r  <= s1_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_r <= in_data;
    end
    if (adv) begin
      out_r <= out_nxt;
    end
  end

  pod_thresh u_thresh (
    .clk          (clk),
    .rst_n        (rst_n),
    .adv          (adv),
    .dither_mode  (dither_mode_r),
    .noise_select (noise_select_r),
    .pix          (s1_r),
    .thr          (thr)
  );

  pod_round u_round_red (
    .en        (color_dither_r),
    .value_in  (s1_r.red_in),
    .thr       (thr.red_thr),
    .value_out (out_nxt.red_out)
  );

  pod_round u_round_green (
    .en        (color_dither_r),
    .value_in  (s1_r.green_in),
    .thr       (thr.green_thr),
    .value_out (out_nxt.green_out)
  );

  pod_round u_round_blue (
    .en        (color_dither_r),
    .value_in  (s1_r.blue_in),
    .thr       (thr.blue_thr),
    .value_out (out_nxt.blue_out)
  );

  assign out_nxt.color_threshold = thr.red_thr;
  assign out_nxt.alpha_threshold = thr.alpha_thr;
  assign out_nxt.noise_word      = {thr.noise, 6'd0} | pod_pkg::NOISE_TAG;

  assign out_valid = out_vld_r;
  assign out_data  = out_r;

endmodule

`default_nettype wire

FILE: src/pod_checker.sv
`default_nettype none

module pod_checker (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_valid,
  input wire logic               in_stall,
  input wire logic               out_valid,
  input wire logic               out_stall,
  input wire pod_pkg::out_beat_t out_data
);

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("out_valid high after reset");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled while result side can move");

  a_beat_reaches_out: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && !out_stall) |=> ##1 out_valid)
    else $error("accepted beat did not reach the result side");

  a_noise_tag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.noise_word[5:0] == 6'h20))
    else $error("noise_word tag bits wrong");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
    else $error("stalled result beat changed");

endmodule

bind pixel_ordered_dither_unit_core pod_checker u_pod_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

`default_nettype wire

FILE: verif/tb_pixel_ordered_dither_unit_core.sv
`timescale 1ns / 100ps

module tb_pixel_ordered_dither_unit_core;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_PAD   = 4;
  localparam int HOLD_CYCLES = 150;
  localparam int MAX_GAP     = 24;
  localparam int SEGMENTS    = 12;
  localparam int SEG_BEATS   = 32;

  localparam logic [2:0] MAGIC_LUT [16] = '{
    3'd0, 3'd6, 3'd1, 3'd7,
    3'd4, 3'd2, 3'd5, 3'd3,
    3'd3, 3'd5, 3'd2, 3'd4,
    3'd7, 3'd1, 3'd6, 3'd0
  };

  localparam logic [2:0] BAYER_LUT [16] = '{
    3'd0, 3'd4, 3'd1, 3'd5,
    3'd4, 3'd0, 3'd5, 3'd1,
    3'd3, 3'd7, 3'd2, 3'd6,
    3'd7, 3'd3, 3'd6, 3'd2
  };

  localparam pod_pkg::out_beat_t NO_BEAT = '0;

  typedef struct packed {
    logic [3:0]         mode;
    logic [1:0]         nsel;
    logic               cen;
    logic               poke_unused;
    pod_pkg::in_beat_t  px;
    logic               has_exp;
    pod_pkg::out_beat_t exp_beat;
  } stim_row_t;

  logic                         clk;
  logic                         rst_n     = 1'b0;
  logic                         in_valid  = 1'b0;
  logic                         in_stall;
  pod_pkg::in_beat_t            in_data   = '0;
  logic                         out_valid;
  logic                         out_stall = 1'b0;
  pod_pkg::out_beat_t           out_data;
  logic                         psel      = 1'b0;
  logic                         penable   = 1'b0;
  logic                         pwrite    = 1'b0;
  logic [pod_pkg::ADDR_W-1:0]   paddr     = '0;
  logic [pod_pkg::DATA_W-1:0]   pwdata    = '0;
  logic [pod_pkg::DATA_W-1:0]   prdata;
  logic                         pready;

  logic [3:0]     mode_q  = pod_pkg::DITHER_MODE_RST;
  pod_pkg::nsel_t nsel_q  = pod_pkg::NSEL_DRAW;
  logic           cen_q   = pod_pkg::COLOR_DITHER_RST;
  logic [2:0]     noise_q = 3'd0;

  pod_pkg::out_beat_t dithered_q [$];
  stim_row_t          dir_rows [$];

  int  err_cnt     = 0;
  int  cycle_cnt   = 0;
  int  tx_idle_pct = 0;
  int  rx_idle_pct = 0;
  bit  hold_req    = 1'b0;
  bit  rx_hold     = 1'b0;

  pixel_ordered_dither_unit_core i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic logic [7:0] round_up(input logic [7:0] v, input logic [2:0] thr);
    if (v[2:0] <= thr) return v;
    if (v > 8'd247) return 8'hFF;
    return (v & 8'hF8) + 8'd8;
  endfunction

  function automatic pod_pkg::out_beat_t dither_pixel(input pod_pkg::in_beat_t px);
    logic [3:0]         idx;
    logic [2:0]         entry;
    logic [2:0]         cthr;
    logic [2:0]         athr;
    logic [2:0]         gthr;
    logic [2:0]         bthr;
    pod_pkg::csel_t     csel;
    pod_pkg::asel_t     asel;
    pod_pkg::out_beat_t res;
    idx  = {px.pixel_y[1:0], px.pixel_x[1:0]};
    csel = pod_pkg::csel_t'(mode_q[3:2]);
    asel = pod_pkg::asel_t'(mode_q[1:0]);
    cthr = 3'd0;
    athr = 3'd0;
    if (nsel_q == pod_pkg::NSEL_DRAW) noise_q = px.random_noise;
    if (nsel_q == pod_pkg::NSEL_DRAW || nsel_q == pod_pkg::NSEL_KEEP) begin
      entry = (csel == pod_pkg::CSEL_MAGIC || csel == pod_pkg::CSEL_RANDOM) ?
              MAGIC_LUT[idx] : BAYER_LUT[idx];
      case (csel)
        pod_pkg::CSEL_MAGIC, pod_pkg::CSEL_BAYER: cthr = entry;
        pod_pkg::CSEL_RANDOM:                     cthr = px.random_color;
        default:                                  cthr = 3'd7;
      endcase
      case (asel)
        pod_pkg::ASEL_SAME:  athr = entry;
        pod_pkg::ASEL_INV:   athr = ~entry;
        pod_pkg::ASEL_NOISE: athr = noise_q;
        default:             athr = 3'd0;
      endcase
    end
    gthr = cthr;
    bthr = cthr;
    if (csel == pod_pkg::CSEL_RANDOM) begin
      gthr = cthr + 3'd3;
      bthr = cthr + 3'd5;
    end
    res.red_out   = px.red_in;
    res.green_out = px.green_in;
    res.blue_out  = px.blue_in;
    if (cen_q) begin
      res.red_out   = round_up(px.red_in, cthr);
      res.green_out = round_up(px.green_in, gthr);
      res.blue_out  = round_up(px.blue_in, bthr);
    end
    res.color_threshold = cthr;
    res.alpha_threshold = athr;
    res.noise_word      = {noise_q, 6'h20};
    return res;
  endfunction

  function automatic pod_pkg::in_beat_t rand_pixel();
    pod_pkg::in_beat_t px;
    px.pixel_x      = 12'($urandom_range(4095));
    px.pixel_y      = 12'($urandom_range(4095));
    px.red_in       = 8'($urandom_range(255));
    px.green_in     = 8'($urandom_range(255));
    px.blue_in      = 8'($urandom_range(255));
    px.random_noise = 3'($urandom_range(7));
    px.random_color = 3'($urandom_range(7));
    if ($urandom_range(3) == 0) begin
      px.red_in   = 8'($urandom_range(255, 240));
      px.green_in = 8'($urandom_range(255, 240));
      px.blue_in  = 8'($urandom_range(255, 240));
    end
    return px;
  endfunction

  task automatic flag_error(input string msg);
    $display("ERROR cycle %0d: %s", cycle_cnt, msg);
    err_cnt++;
  endtask

  task automatic cmp_field(input string name, input int got, input int want);
    if (got != want) flag_error($sformatf("%s got %0d expected %0d", name, got, want));
  endtask

  task automatic check_beat(input pod_pkg::out_beat_t got);
    pod_pkg::out_beat_t want;
    if (dithered_q.size() == 0) begin
      flag_error($sformatf("unexpected result beat %h", got));
      return;
    end
    want = dithered_q.pop_front();
    cmp_field("red_out", int'(got.red_out), int'(want.red_out));
    cmp_field("green_out", int'(got.green_out), int'(want.green_out));
    cmp_field("blue_out", int'(got.blue_out), int'(want.blue_out));
    cmp_field("color_threshold", int'(got.color_threshold), int'(want.color_threshold));
    cmp_field("alpha_threshold", int'(got.alpha_threshold), int'(want.alpha_threshold));
    cmp_field("noise_word", int'(got.noise_word), int'(want.noise_word));
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) check_beat(out_data);
  end

  always @(posedge clk) begin
    out_stall <= rx_hold || ($urandom_range(99) < rx_idle_pct);
  end

  initial begin : rx_holdoff
    wait (hold_req);
    @(posedge clk);
    rx_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    rx_hold <= 1'b0;
  end

  task automatic send_pixel(input pod_pkg::in_beat_t px, input logic has_exp,
                            input pod_pkg::out_beat_t exp_beat);
    int gap;
    pod_pkg::out_beat_t pred;
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(99) < tx_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= px;
    do @(posedge clk); while (in_stall);
    pred = dither_pixel(px);
    dithered_q.push_back(has_exp ? exp_beat : pred);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (dithered_q.size() != 0) @(posedge clk);
    repeat (DRAIN_PAD) @(posedge clk);
  endtask

  task automatic apb_write(input pod_pkg::reg_idx_t idx,
                           input logic [pod_pkg::DATA_W-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      pod_pkg::REG_DITHER_MODE:  mode_q = val[3:0];
      pod_pkg::REG_NOISE_SELECT: nsel_q = pod_pkg::nsel_t'(val[1:0]);
      pod_pkg::REG_COLOR_DITHER: cen_q  = val[0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic load_setup(input logic [3:0] mode, input logic [1:0] nsel, input logic cen);
    logic [pod_pkg::DATA_W-1:0] val;
    wait_drained();
    val = $urandom();
    val[3:0] = mode;
    apb_write(pod_pkg::REG_DITHER_MODE, val);
    val = $urandom();
    val[1:0] = nsel;
    apb_write(pod_pkg::REG_NOISE_SELECT, val);
    val = $urandom();
    val[0] = cen;
    apb_write(pod_pkg::REG_COLOR_DITHER, val);
  endtask

  task automatic add_row(input logic [3:0] mode, input pod_pkg::nsel_t nsel, input logic cen,
                         input logic poke, input logic [11:0] x, input logic [11:0] y,
                         input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
                         input logic [2:0] rn, input logic [2:0] rc,
                         input logic has_exp, input pod_pkg::out_beat_t exp_beat);
    stim_row_t row;
    row.mode        = mode;
    row.nsel        = nsel;
    row.cen         = cen;
    row.poke_unused = poke;
    row.px          = {x, y, r, g, b, rn, rc};
    row.has_exp     = has_exp;
    row.exp_beat    = exp_beat;
    dir_rows.push_back(row);
  endtask

  initial begin : main_seq
    stim_row_t row;
    int        tx_pct [3];
    int        rx_pct [3];
    tx_pct = '{8, 61, 0};
    rx_pct = '{61, 8, 0};

    add_row({pod_pkg::CSEL_CONST, pod_pkg::ASEL_ZERO}, pod_pkg::NSEL_DRAW, 1'b1, 1'b0,
            12'h000, 12'h000, 8'h00, 8'h00, 8'h00, 3'd0, 3'd0,
            1'b1, {8'h00, 8'h00, 8'h00, 3'd7, 3'd0, 9'h020});
    add_row({pod_pkg::CSEL_CONST, pod_pkg::ASEL_ZERO}, pod_pkg::NSEL_DRAW, 1'b1, 1'b0,
            12'hFFF, 12'hFFF, 8'hFF, 8'hFF, 8'hFF, 3'd7, 3'd7,
            1'b1, {8'hFF, 8'hFF, 8'hFF, 3'd7, 3'd0, 9'h1E0});
    add_row({pod_pkg::CSEL_MAGIC, pod_pkg::ASEL_SAME}, pod_pkg::NSEL_DRAW, 1'b1, 1'b0,
            12'h000, 12'h000, 8'h01, 8'h00, 8'hF9, 3'd5, 3'd0,
            1'b1, {8'h08, 8'h00, 8'hFF, 3'd0, 3'd0, 9'h160});
    add_row({pod_pkg::CSEL_MAGIC, pod_pkg::ASEL_SAME}, pod_pkg::NSEL_DRAW, 1'b1, 1'b0,
            12'h003, 12'h002, 8'h15, 8'h14, 8'hF7, 3'd2, 3'd0,
            1'b1, {8'h18, 8'h14, 8'hF8, 3'd4, 3'd4, 9'h0A0});
    add_row({pod_pkg::CSEL_MAGIC, pod_pkg::ASEL_INV}, pod_pkg::NSEL_DRAW, 1'b1, 1'b0,
            12'hAA9, 12'h554, 8'hA3, 8'h5C, 8'hF0, 3'd6, 3'd3, 1'b0, NO_BEAT);
    add_row({pod_pkg::CSEL_MAGIC, pod_pkg::ASEL_NOISE}, pod_pkg::NSEL_DRAW, 1'b1, 1'b0,
            12'h802, 12'h401, 8'h7F, 8'h80, 8'hFE, 3'd4, 3'd1, 1'b0, NO_BEAT);
    add_row({pod_pkg::CSEL_MAGIC, pod_pkg::ASEL_ZERO}, pod_pkg::NSEL_DRAW, 1'b1, 1'b0,
            12'h123, 12'h3FD, 8'h3E, 8'hC5, 8'h0F, 3'd1, 3'd6, 1'b0, NO_BEAT);
    add_row({pod_pkg::CSEL_BAYER, pod_pkg::ASEL_SAME}, pod_pkg::NSEL_DRAW, 1'b1, 1'b0,
            12'h001, 12'h003, 8'h66, 8'h99, 8'hF5, 3'd3, 3'd2, 1'b0, NO_BEAT);
    add_row({pod_pkg::CSEL_BAYER, pod_pkg::ASEL_INV}, pod_pkg::NSEL_DRAW, 1'b1, 1'b0,
            12'hFFE, 12'h002, 8'hFB, 8'h04, 8'h83, 3'd7, 3'd5, 1'b0, NO_BEAT);
    add_row({pod_pkg::CSEL_BAYER, pod_pkg::ASEL_NOISE}, pod_pkg::NSEL_DRAW, 1'b1, 1'b0,
            12'h7FC, 12'hFFD, 8'h21, 8'h47, 8'hD6, 3'd2, 3'd7, 1'b0, NO_BEAT);
    add_row({pod_pkg::CSEL_BAYER, pod_pkg::ASEL_ZERO}, pod_pkg::NSEL_DRAW, 1'b1, 1'b0,
            12'h00F, 12'h0F0, 8'hF8, 8'h5D, 8'h1A, 3'd6, 3'd4, 1'b0, NO_BEAT);
    add_row({pod_pkg::CSEL_RANDOM, pod_pkg::ASEL_SAME}, pod_pkg::NSEL_DRAW, 1'b1, 1'b0,
            12'h3C1, 12'hC32, 8'h01, 8'h04, 8'h06, 3'd5, 3'd0, 1'b0, NO_BEAT);
    add_row({pod_pkg::CSEL_RANDOM, pod_pkg::ASEL_INV}, pod_pkg::NSEL_DRAW, 1'b1, 1'b0,
            12'h5A7, 12'hA5B, 8'hF7, 8'hFF, 8'h07, 3'd0, 3'd7, 1'b0, NO_BEAT);
    add_row({pod_pkg::CSEL_RANDOM, pod_pkg::ASEL_NOISE}, pod_pkg::NSEL_DRAW, 1'b1, 1'b0,
            12'hE00, 12'h1FF, 8'h0B, 8'hFA, 8'h6C, 3'd3, 3'd4, 1'b0, NO_BEAT);
    add_row({pod_pkg::CSEL_RANDOM, pod_pkg::ASEL_ZERO}, pod_pkg::NSEL_DRAW, 1'b1, 1'b0,
            12'h802, 12'h802, 8'h92, 8'h2D, 8'hBE, 3'd1, 3'd2, 1'b0, NO_BEAT);
    add_row({pod_pkg::CSEL_CONST, pod_pkg::ASEL_SAME}, pod_pkg::NSEL_DRAW, 1'b1, 1'b0,
            12'h402, 12'h201, 8'hFF, 8'h00, 8'h77, 3'd5, 3'd6, 1'b0, NO_BEAT);
    add_row({pod_pkg::CSEL_CONST, pod_pkg::ASEL_INV}, pod_pkg::NSEL_DRAW, 1'b1, 1'b0,
            12'h003, 12'h001, 8'h55, 8'hAA, 8'hCC, 3'd7, 3'd1, 1'b0, NO_BEAT);
    add_row({pod_pkg::CSEL_CONST, pod_pkg::ASEL_NOISE}, pod_pkg::NSEL_DRAW, 1'b1, 1'b0,
            12'h101, 12'h010, 8'h33, 8'hEF, 8'h1E, 3'd6, 3'd3, 1'b0, NO_BEAT);
    add_row({pod_pkg::CSEL_RANDOM, pod_pkg::ASEL_NOISE}, pod_pkg::NSEL_KEEP, 1'b1, 1'b0,
            12'h002, 12'h003, 8'h2B, 8'h3C, 8'h4D, 3'd7, 3'd5, 1'b0, NO_BEAT);
    add_row({pod_pkg::CSEL_RANDOM, pod_pkg::ASEL_NOISE}, pod_pkg::NSEL_KEEP, 1'b1, 1'b0,
            12'hFFD, 12'hFFE, 8'hFC, 8'h09, 8'hE3, 3'd0, 3'd2, 1'b0, NO_BEAT);
    add_row({pod_pkg::CSEL_RANDOM, pod_pkg::ASEL_SAME}, pod_pkg::NSEL_NONE, 1'b1, 1'b0,
            12'h001, 12'h001, 8'hFF, 8'h07, 8'h00, 3'd4, 3'd6, 1'b0, NO_BEAT);
    add_row({pod_pkg::CSEL_BAYER, pod_pkg::ASEL_NOISE}, pod_pkg::NSEL_RSVD, 1'b1, 1'b0,
            12'hABC, 12'hDEF, 8'h8F, 8'h73, 8'hF6, 3'd1, 3'd7, 1'b0, NO_BEAT);
    add_row({pod_pkg::CSEL_MAGIC, pod_pkg::ASEL_SAME}, pod_pkg::NSEL_DRAW, 1'b0, 1'b0,
            12'h000, 12'h000, 8'h07, 8'hFF, 8'h81, 3'd3, 3'd7,
            1'b1, {8'h07, 8'hFF, 8'h81, 3'd0, 3'd0, 9'h0E0});
    add_row({pod_pkg::CSEL_MAGIC, pod_pkg::ASEL_SAME}, pod_pkg::NSEL_DRAW, 1'b0, 1'b1,
            12'h003, 12'h003, 8'hF9, 8'h0E, 8'h35, 3'd2, 3'd4, 1'b0, NO_BEAT);

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    tx_idle_pct = tx_pct[0];
    rx_idle_pct = rx_pct[0];
    foreach (dir_rows[i]) begin
      row = dir_rows[i];
      if (row.mode != mode_q || row.nsel != nsel_q || row.cen != cen_q)
        load_setup(row.mode, row.nsel, row.cen);
      if (row.poke_unused) begin
        wait_drained();
        apb_write(pod_pkg::REG_UNUSED, 32'hFFFF_FFFF);
      end
      send_pixel(row.px, row.has_exp, row.exp_beat);
    end

    for (int ph = 0; ph < 3; ph++) begin
      tx_idle_pct = tx_pct[ph];
      rx_idle_pct = rx_pct[ph];
      for (int seg = 0; seg < SEGMENTS; seg++) begin
        load_setup(4'($urandom_range(15)), 2'($urandom_range(3)), 1'($urandom_range(1)));
        if ($urandom_range(3) == 0) apb_write(pod_pkg::REG_UNUSED, $urandom());
        if (ph == 2 && seg == 1) hold_req = 1'b1;
        for (int n = 0; n < SEG_BEATS; n++) send_pixel(rand_pixel(), 1'b0, NO_BEAT);
      end
    end

    wait_drained();
    if (err_cnt == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule

FILE: filelist.f
src/pod_pkg.sv
src/pod_thresh.sv
src/pod_round.sv
src/pixel_ordered_dither_unit_core.sv
src/pod_checker.sv
verif/tb_pixel_ordered_dither_unit_core.sv
